/* hdl/cclag_pkg.sv */
// ----------------------------------------------------------------------------
// Cross-correlation lag search package
// Field widths, register reset values, opcodes and register indexes shared
// by the lag search block.
// ----------------------------------------------------------------------------
package cclag_pkg;

	// Payload and register widths.
	localparam int SAMPLE_W  = 16;
	localparam int OPCODE_W  = 2;
	localparam int LAG_OUT_W = 14;
	localparam int MAG_W     = 43;
	localparam int THR_W     = 40;
	localparam int SKIP_W    = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 40;

	// Default depth of each sample store.
	localparam int MAX_SAMPLES_DEF = 4096;

	// Register reset values: the threshold is 0.1 in Q30.
	localparam logic [THR_W-1:0]  THR_RESET  = 40'd107374182;
	localparam logic [SKIP_W-1:0] SKIP_RESET = 10'd100;

	// Largest magnitude the result can carry.
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// Item opcodes.
	localparam logic [OPCODE_W-1:0] OP_LOAD_REF = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD_PRB = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SEARCH   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_SKIP      = 1'd1;

endpackage

/* hdl/cross_correlation_lag_search.sv */
// A load beat gives no result. A search visits each lag in turn: one read
// of each memory per cycle across the overlap, a pipeline drain, then the
// magnitude and its comparison; an empty overlap skips reads and drain.
// Throughput: one load per cycle while idle; one search at a time, stalling
// input for the whole lag walk. Reset: asynchronous, clears counts, registers
// and control; the sample memories are not cleared, read only below counts.
// ----------------------------------------------------------------------------
// Cross-correlation lag search
// Loads a reference and a probe sequence into two memories, then walks the
// lag range, forming each overlap dot product with a multiply-accumulate
// pipeline, and reports the visited lag with the greatest absolute sum.
// ----------------------------------------------------------------------------
module cross_correlation_lag_search #(
	parameter int MAX_SAMPLES = cclag_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port
	input  logic                                   cfg_we,
	input  logic [cclag_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cclag_pkg::CFG_DAT_W-1:0]        cfg_data,
	// Item channel
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic [cclag_pkg::OPCODE_W-1:0]         opcode,
	input  logic signed [cclag_pkg::SAMPLE_W-1:0]  sample_value,
	// Result channel
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [cclag_pkg::LAG_OUT_W-1:0] best_lag,
	output logic [cclag_pkg::MAG_W-1:0]            best_magnitude
);

	// Derived sizes.
	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int LW    = $clog2(MAX_SAMPLES + 1026) + 1;
	localparam int PW    = 2 * cclag_pkg::SAMPLE_W;
	localparam int ACCW  = AW + 32;
	localparam int XW    = (ACCW > cclag_pkg::MAG_W) ? ACCW : cclag_pkg::MAG_W;
	localparam int EW    = (LW > cclag_pkg::LAG_OUT_W) ? LW : cclag_pkg::LAG_OUT_W;
	localparam int M10W  = cclag_pkg::MAG_W + 4;
	localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SAMPLES);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_MAG   = 3'd4;
	localparam logic [2:0] ST_EVAL  = 3'd5;

	logic [2:0] state_q;

	// Configuration registers.
	logic [cclag_pkg::THR_W-1:0]  low_threshold_q;
	logic [cclag_pkg::SKIP_W-1:0] far_skip_q;

	// Sample memories and their registered read data.
	logic [cclag_pkg::SAMPLE_W-1:0] ref_mem [MAX_SAMPLES];
	logic [cclag_pkg::SAMPLE_W-1:0] prb_mem [MAX_SAMPLES];
	logic signed [cclag_pkg::SAMPLE_W-1:0] ref_rd_s1;
	logic signed [cclag_pkg::SAMPLE_W-1:0] prb_rd_s1;

	// Walk state.
	logic [CW-1:0]          ref_count_q;
	logic [CW-1:0]          prb_count_q;
	logic signed [LW-1:0]   lag_q;
	logic signed [LW-1:0]   best_lag_q;
	logic [cclag_pkg::MAG_W-1:0] best_q;
	logic [cclag_pkg::MAG_W-1:0] cur_q;
	logic [AW-1:0]          idx_q;
	logic signed [LW-1:0]   to_q;
	logic signed [ACCW-1:0] acc_q;

	// Multiply-accumulate pipeline.
	logic                   v_s1;
	logic                   v_s2;
	logic signed [PW-1:0]   prod_s2;

	// Result register.
	logic                                   res_valid_q;
	logic signed [cclag_pkg::LAG_OUT_W-1:0] res_lag_q;
	logic [cclag_pkg::MAG_W-1:0]            res_mag_q;

	// Combinational helpers.
	logic                   item_acc;
	logic signed [LW-1:0]   ref_count_s;
	logic signed [LW-1:0]   prb_count_s;
	logic signed [LW-1:0]   from_c;
	logic signed [LW-1:0]   end_c;
	logic signed [LW-1:0]   to_c;
	logic signed [LW-1:0]   idx_s;
	logic signed [LW-1:0]   prb_idx_s;
	logic [AW-1:0]          prb_addr;
	logic                   run_last;
	logic [ACCW-1:0]        abs_acc;
	logic [XW-1:0]          abs_x;
	logic [cclag_pkg::MAG_W-1:0] mag_c;
	logic [M10W-1:0]        cur_x10;
	logic signed [EW-1:0]   best_lag_ext;

	// A search waits while an earlier result is still held.
	assign item_ready = (state_q == ST_IDLE) &&
		!((opcode == cclag_pkg::OP_SEARCH) && res_valid_q);
	assign item_acc = item_valid && item_ready;

	// Overlap bounds of the current lag.
	assign ref_count_s = signed'(LW'(ref_count_q));
	assign prb_count_s = signed'(LW'(prb_count_q));
	assign from_c      = (lag_q > 0) ? lag_q : '0;
	assign end_c       = prb_count_s + lag_q;
	assign to_c        = (end_c > ref_count_s) ? ref_count_s : end_c;

	// Read addresses while the overlap is being summed.
	assign idx_s     = signed'(LW'(idx_q));
	assign prb_idx_s = idx_s - lag_q;
	assign prb_addr  = prb_idx_s[AW-1:0];
	assign run_last  = (idx_s + LW'(1)) == to_q;

	// Saturated magnitude of the finished sum.
	assign abs_acc = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
	assign abs_x   = XW'(abs_acc);
	assign mag_c   = (abs_x > XW'(cclag_pkg::MAG_MAX)) ? cclag_pkg::MAG_MAX
		: abs_x[cclag_pkg::MAG_W-1:0];

	// Ten times the current magnitude, by shift and add.
	assign cur_x10 = (M10W'(cur_q) << 3) + (M10W'(cur_q) << 1);

	// The reported lag is the walk lag taken to the output width.
	assign best_lag_ext = EW'(best_lag_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q <= cclag_pkg::THR_RESET;
			far_skip_q      <= cclag_pkg::SKIP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cclag_pkg::REG_LOW_THRESHOLD: begin
					low_threshold_q <= cfg_data[cclag_pkg::THR_W-1:0];
				end
				cclag_pkg::REG_FAR_SKIP: begin
					far_skip_q <= cfg_data[cclag_pkg::SKIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sample memories: written by load beats, read during the walk.
	always_ff @(posedge clk) begin
		if (item_acc && (opcode == cclag_pkg::OP_LOAD_REF) && (ref_count_q < COUNT_FULL)) begin
			ref_mem[ref_count_q[AW-1:0]] <= sample_value;
		end
		if (item_acc && (opcode == cclag_pkg::OP_LOAD_PRB) && (prb_count_q < COUNT_FULL)) begin
			prb_mem[prb_count_q[AW-1:0]] <= sample_value;
		end
		ref_rd_s1 <= signed'(ref_mem[idx_q]);
		prb_rd_s1 <= signed'(prb_mem[prb_addr]);
	end

	// Product stage, no reset needed on the payload.
	always_ff @(posedge clk) begin
		prod_s2 <= ref_rd_s1 * prb_rd_s1;
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
		end
	end

	// Sequencer: loads, lag walk and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_count_q <= '0;
			prb_count_q <= '0;
			lag_q       <= '0;
			best_lag_q  <= '0;
			best_q      <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			to_q        <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
			res_lag_q   <= '0;
			res_mag_q   <= '0;
		end else begin
			// The held result leaves on its beat.
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end

			// Products enter the sum as they arrive.
			if (v_s2) begin
				acc_q <= acc_q + ACCW'(prod_s2);
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (opcode)
							cclag_pkg::OP_LOAD_REF: begin
								if (ref_count_q < COUNT_FULL) begin
									ref_count_q <= ref_count_q + CW'(1);
								end
							end
							cclag_pkg::OP_LOAD_PRB: begin
								if (prb_count_q < COUNT_FULL) begin
									prb_count_q <= prb_count_q + CW'(1);
								end
							end
							cclag_pkg::OP_SEARCH: begin
								// The first lag has an empty overlap and a zero sum.
								best_lag_q <= -prb_count_s;
								best_q     <= '0;
								lag_q      <= LW'(1) - prb_count_s;
								state_q    <= ST_START;
							end
							default: begin
							end
						endcase
					end
				end
				ST_START: begin
					if (lag_q > ref_count_s) begin
						// Walk complete: hand over the best lag and clear the counts.
						res_valid_q <= 1'b1;
						res_lag_q   <= best_lag_ext[cclag_pkg::LAG_OUT_W-1:0];
						res_mag_q   <= best_q;
						ref_count_q <= '0;
						prb_count_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						acc_q <= '0;
						idx_q <= from_c[AW-1:0];
						to_q  <= to_c;
						state_q <= (from_c < to_c) ? ST_RUN : ST_MAG;
					end
				end
				ST_RUN: begin
					// One read of each memory per cycle across the overlap.
					if (run_last) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					cur_q   <= mag_c;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// A strictly greater sum wins; otherwise the walk may skip past weak sums.
					if (cur_q > best_q) begin
						best_q     <= cur_q;
						best_lag_q <= lag_q;
						lag_q      <= lag_q + LW'(1);
					end else if (cur_x10 < M10W'(best_q)) begin
						lag_q <= lag_q + LW'(2);
					end else if (cur_q < cclag_pkg::MAG_W'(low_threshold_q)) begin
						lag_q <= lag_q + LW'(1) + signed'(LW'(far_skip_q));
					end else begin
						lag_q <= lag_q + LW'(1);
					end
					state_q <= ST_START;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result outputs.
	assign result_valid   = res_valid_q;
	assign best_lag       = res_lag_q;
	assign best_magnitude = res_mag_q;

endmodule

/* test/cross_correlation_lag_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-correlation lag search testbench
// Loads reference and probe sequences and runs searches. Each search is
// predicted by walking the lags on a private copy of both sample stores.
// The reported lag and magnitude of every result beat are checked against
// that prediction. Both channels stall at random, and the two registers go
// through several settings, the extremes among them.
// ----------------------------------------------------------------------------

// One expected search result.
typedef struct {
	logic signed [cclag_pkg::LAG_OUT_W-1:0] lag;
	logic [cclag_pkg::MAG_W-1:0]            mag;
} peak_t;

// Keeps a copy of the sample stores and registers, predicts the peak of each
// search and compares the result beats with those predictions in order.
class peak_lag_scoreboard;
	logic signed [cclag_pkg::SAMPLE_W-1:0] ref_mem [cclag_pkg::MAX_SAMPLES_DEF];
	logic signed [cclag_pkg::SAMPLE_W-1:0] prb_mem [cclag_pkg::MAX_SAMPLES_DEF];
	int                                    ref_len;
	int                                    prb_len;
	logic [cclag_pkg::THR_W-1:0]           low_threshold;
	logic [cclag_pkg::SKIP_W-1:0]          far_skip;
	peak_t                                 expected_peaks[$];
	int unsigned                           mismatches;
	int unsigned                           peaks_checked;

	function new();
		ref_len = 0;
		prb_len = 0;
		low_threshold = cclag_pkg::THR_RESET;
		far_skip = cclag_pkg::SKIP_RESET;
		mismatches = 0;
		peaks_checked = 0;
	endfunction

	function void set_register(logic [cclag_pkg::CFG_IDX_W-1:0] idx,
		logic [cclag_pkg::CFG_DAT_W-1:0] data);
		case (idx)
			cclag_pkg::REG_LOW_THRESHOLD: low_threshold = data[cclag_pkg::THR_W-1:0];
			cclag_pkg::REG_FAR_SKIP:      far_skip = data[cclag_pkg::SKIP_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_peaks.size();
	endfunction

	// Exact dot product of the overlapping samples at one lag.
	function longint overlap_sum(longint lag);
		longint lo, hi, acc;
		lo = (lag > 0) ? lag : 0;
		hi = prb_len + lag;
		if (hi > ref_len)
			hi = ref_len;
		acc = 0;
		for (longint i = lo; i < hi; i++)
			acc += longint'(ref_mem[i]) * longint'(prb_mem[i - lag]);
		return acc;
	endfunction

	function longint magnitude(longint s);
		longint m;
		m = (s < 0) ? -s : s;
		if (m > longint'(cclag_pkg::MAG_MAX))
			m = longint'(cclag_pkg::MAG_MAX);
		return m;
	endfunction

	// Takes one accepted input beat; a search queues its predicted peak.
	function void note_item(logic [cclag_pkg::OPCODE_W-1:0] op,
		logic signed [cclag_pkg::SAMPLE_W-1:0] smp);
		longint lag, stop_lag, best_at, best, cur;
		peak_t  exp_peak;
		case (op)
			cclag_pkg::OP_LOAD_REF: begin
				if (ref_len < cclag_pkg::MAX_SAMPLES_DEF) begin
					ref_mem[ref_len] = smp;
					ref_len++;
				end
			end
			cclag_pkg::OP_LOAD_PRB: begin
				if (prb_len < cclag_pkg::MAX_SAMPLES_DEF) begin
					prb_mem[prb_len] = smp;
					prb_len++;
				end
			end
			cclag_pkg::OP_SEARCH: begin
				// Walk from minus the probe length; the walk thins out
				// after lags that do not improve the best.
				lag = -prb_len;
				stop_lag = ref_len + 1;
				best_at = lag;
				best = magnitude(overlap_sum(lag));
				for (lag = lag + 1; lag < stop_lag; lag++) begin
					cur = magnitude(overlap_sum(lag));
					if (cur > best) begin
						best = cur;
						best_at = lag;
					end else if (cur * 10 < best) begin
						lag += 1;
					end else if (cur < longint'(low_threshold)) begin
						lag += longint'(far_skip);
					end
				end
				exp_peak.lag = best_at[cclag_pkg::LAG_OUT_W-1:0];
				exp_peak.mag = best[cclag_pkg::MAG_W-1:0];
				expected_peaks.insert(expected_peaks.size(), exp_peak);
				ref_len = 0;
				prb_len = 0;
			end
			default: ;
		endcase
	endfunction

	function void check_peak(logic signed [cclag_pkg::LAG_OUT_W-1:0] lag,
		logic [cclag_pkg::MAG_W-1:0] mag);
		peak_t exp_peak;
		if (expected_peaks.size() == 0) begin
			$error("result beat with no search outstanding: best_lag %0d best_magnitude %0d",
				lag, mag);
			mismatches++;
			return;
		end
		exp_peak = expected_peaks.pop_front();
		peaks_checked++;
		if (lag !== exp_peak.lag) begin
			$error("best_lag: expected %0d, actual %0d", exp_peak.lag, lag);
			mismatches++;
		end
		if (mag !== exp_peak.mag) begin
			$error("best_magnitude: expected %0d, actual %0d", exp_peak.mag, mag);
			mismatches++;
		end
	endfunction
endclass

module tb;

	localparam logic [cclag_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int QUIET_CYCLES = 16;
	localparam int IDLE_PCT = 11;
	localparam int PHASE_ITEMS = 160;
	localparam int PHASE_SEARCHES = 12;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   cfg_we;
	logic [cclag_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [cclag_pkg::CFG_DAT_W-1:0]        cfg_data;
	logic                                   item_valid;
	logic                                   item_ready;
	logic [cclag_pkg::OPCODE_W-1:0]         opcode;
	logic signed [cclag_pkg::SAMPLE_W-1:0]  sample_value;
	logic                                   result_valid;
	logic                                   result_ready;
	logic signed [cclag_pkg::LAG_OUT_W-1:0] best_lag;
	logic [cclag_pkg::MAG_W-1:0]            best_magnitude;

	peak_lag_scoreboard sb;
	bit          idling = 1'b1;
	longint      cycles = 0;
	int unsigned items_sent = 0;
	int unsigned searches_sent = 0;
	int unsigned unused_sent = 0;
	int unsigned settings_used = 0;

	cross_correlation_lag_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.opcode         (opcode),
		.sample_value   (sample_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.best_lag       (best_lag),
		.best_magnitude (best_magnitude)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run length guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: stall at random while idling is on.
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ready <= !(idling && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Nothing changes between the falling edge and the next rising edge, so a
	// beat seen here is the one taken at that rising edge.
	always @(negedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_peak(best_lag, best_magnitude);
	end

	// Presents one input beat and returns at the rising edge that takes it.
	task automatic send_item(input logic [cclag_pkg::OPCODE_W-1:0] op,
		input logic signed [cclag_pkg::SAMPLE_W-1:0] smp);
		int unsigned gap;
		bit          taken;
		gap = 0;
		while (idling && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		sample_value <= smp;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = item_ready;
			@(posedge clk);
		end
		sb.note_item(op, smp);
		if (op == OP_UNUSED)
			unused_sent++;
		else
			items_sent++;
		if (op == cclag_pkg::OP_SEARCH)
			searches_sent++;
	endtask

	// Stops sending until every predicted result has come back, then lets
	// the block go quiet.
	task automatic hold_until_drained();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Writes both registers; only called while the block is idle.
	task automatic set_search_regs(input logic [cclag_pkg::THR_W-1:0] thr,
		input logic [cclag_pkg::SKIP_W-1:0] skip);
		cfg_we <= 1'b1;
		cfg_index <= cclag_pkg::REG_LOW_THRESHOLD;
		cfg_data <= cclag_pkg::CFG_DAT_W'(thr);
		@(posedge clk);
		cfg_index <= cclag_pkg::REG_FAR_SKIP;
		cfg_data <= cclag_pkg::CFG_DAT_W'(skip);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(cclag_pkg::REG_LOW_THRESHOLD, cclag_pkg::CFG_DAT_W'(thr));
		sb.set_register(cclag_pkg::REG_FAR_SKIP, cclag_pkg::CFG_DAT_W'(skip));
		settings_used++;
	endtask

	// Sequence lengths: mostly short, now and then longer.
	function automatic int pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 13);
		return $urandom_range(12, 0);
	endfunction

	// Sample content by style: full range, small, or the extreme values.
	function automatic logic signed [cclag_pkg::SAMPLE_W-1:0] pick_sample(int style);
		int v;
		case (style)
			1: begin
				v = $urandom_range(128);
				return cclag_pkg::SAMPLE_W'(v - 64);
			end
			3: begin
				case ($urandom_range(4))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return 16'sd1;
					3: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: return cclag_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// One pair of sequences with loads interleaved at random, then mostly a
	// search. A pair left without a search runs on into the next one.
	task automatic load_and_search();
		int                                    ref_n, prb_n, style, shift, ri, pi;
		logic signed [cclag_pkg::SAMPLE_W-1:0] ref_vals[$];
		logic signed [cclag_pkg::SAMPLE_W-1:0] prb_vals[$];
		ref_n = pick_len();
		prb_n = pick_len();
		style = $urandom_range(3);
		for (int k = 0; k < ref_n; k++)
			ref_vals.insert(ref_vals.size(), pick_sample(style));
		// Style two copies the probe out of the reference to give a clear peak.
		shift = (prb_n <= ref_n) ? $urandom_range(ref_n - prb_n) : 0;
		for (int k = 0; k < prb_n; k++) begin
			if (style == 2 && prb_n <= ref_n)
				prb_vals.insert(prb_vals.size(), ref_vals[shift + k]);
			else
				prb_vals.insert(prb_vals.size(), pick_sample(style));
		end
		ri = 0;
		pi = 0;
		while (ri < ref_n || pi < prb_n) begin
			if ($urandom_range(24) == 0)
				send_item(OP_UNUSED, cclag_pkg::SAMPLE_W'($urandom));
			if (pi >= prb_n || (ri < ref_n && $urandom_range(1) == 1)) begin
				send_item(cclag_pkg::OP_LOAD_REF, ref_vals[ri]);
				ri++;
			end else begin
				send_item(cclag_pkg::OP_LOAD_PRB, prb_vals[pi]);
				pi++;
			end
		end
		if ($urandom_range(11) != 0) begin
			send_item(cclag_pkg::OP_SEARCH, cclag_pkg::SAMPLE_W'($urandom));
			if ($urandom_range(4) == 0)
				hold_until_drained();
		end
	endtask

	// A run of random sequences under one register setting.
	task automatic random_phase(input logic [cclag_pkg::THR_W-1:0] thr,
		input logic [cclag_pkg::SKIP_W-1:0] skip);
		int unsigned items_at, searches_at;
		hold_until_drained();
		set_search_regs(thr, skip);
		items_at = items_sent;
		searches_at = searches_sent;
		while (items_sent - items_at < PHASE_ITEMS
			|| searches_sent - searches_at < PHASE_SEARCHES)
			load_and_search();
	endtask

	initial begin
		logic [cclag_pkg::THR_W-1:0] rand_thr;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= cclag_pkg::REG_LOW_THRESHOLD;
		cfg_data <= '0;
		item_valid <= 1'b0;
		opcode <= cclag_pkg::OP_LOAD_REF;
		sample_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Both stores empty, then a lone probe sample, then a lone reference.
		send_item(cclag_pkg::OP_SEARCH, 16'sd32767);
		send_item(cclag_pkg::OP_LOAD_PRB, -16'sd32768);
		send_item(cclag_pkg::OP_SEARCH, 16'sd0);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd32767);
		send_item(cclag_pkg::OP_SEARCH, -16'sd1);
		// Extreme samples interleaved, with an unused opcode in between.
		send_item(cclag_pkg::OP_LOAD_REF, -16'sd32768);
		send_item(cclag_pkg::OP_LOAD_PRB, -16'sd32768);
		send_item(OP_UNUSED, 16'sh5A5A);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd32767);
		send_item(cclag_pkg::OP_LOAD_PRB, -16'sd32768);
		send_item(cclag_pkg::OP_LOAD_REF, -16'sd32768);
		send_item(cclag_pkg::OP_SEARCH, -16'sd32768);
		// Two equal sums: the earlier lag must be kept.
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd16384);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd16384);
		send_item(cclag_pkg::OP_LOAD_PRB, 16'sd16384);
		send_item(cclag_pkg::OP_SEARCH, 16'sd0);
		// A peak followed by a sharp drop, then small values.
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd32767);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd0);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd3);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd1);
		send_item(cclag_pkg::OP_LOAD_PRB, 16'sd32767);
		send_item(cclag_pkg::OP_LOAD_PRB, 16'sd2);
		send_item(cclag_pkg::OP_SEARCH, 16'sd1);
		hold_until_drained();

		// Full stores with no idling: the extra load into a full store is
		// dropped. A peak on the last reference entry, then a zero reference
		// that leaves the best at the very first lag.
		idling = 1'b0;
		set_search_regs('0, {cclag_pkg::SKIP_W{1'b1}});
		for (int k = 0; k <= cclag_pkg::MAX_SAMPLES_DEF; k++) begin
			if (k == cclag_pkg::MAX_SAMPLES_DEF - 1)
				send_item(cclag_pkg::OP_LOAD_REF, -16'sd32768);
			else if (k == cclag_pkg::MAX_SAMPLES_DEF)
				send_item(cclag_pkg::OP_LOAD_REF, 16'sd32767);
			else
				send_item(cclag_pkg::OP_LOAD_REF, 16'sd0);
		end
		send_item(cclag_pkg::OP_LOAD_PRB, 16'sd32767);
		send_item(cclag_pkg::OP_SEARCH, 16'sd0);
		for (int k = 0; k <= cclag_pkg::MAX_SAMPLES_DEF; k++)
			send_item(cclag_pkg::OP_LOAD_PRB, cclag_pkg::SAMPLE_W'($urandom));
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd0);
		send_item(cclag_pkg::OP_LOAD_REF, 16'sd0);
		send_item(cclag_pkg::OP_SEARCH, 16'sd0);
		hold_until_drained();
		idling = 1'b1;

		// Random sequences under several register settings.
		random_phase(cclag_pkg::THR_RESET, cclag_pkg::SKIP_RESET);
		random_phase('0, '0);
		random_phase({cclag_pkg::THR_W{1'b1}}, {cclag_pkg::SKIP_W{1'b1}});
		rand_thr = cclag_pkg::THR_W'({$urandom, $urandom} >> $urandom_range(39));
		random_phase(rand_thr, cclag_pkg::SKIP_W'($urandom));
		random_phase(cclag_pkg::THR_W'(64'd1 << 30), cclag_pkg::SKIP_W'(1));
		hold_until_drained();

		$display("Sent %0d load and search beats (%0d searches, full-store fills included)",
			items_sent, searches_sent);
		$display("plus %0d unused-opcode beats; %0d register settings; %0d results checked.",
			unused_sent, settings_used, sb.peaks_checked);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* cross_correlation_lag_search.f */
hdl/cclag_pkg.sv
hdl/cross_correlation_lag_search.sv
test/cross_correlation_lag_search_tb.sv
